@@ rtl/gcd_pkg.sv @@
// Shared constants, widths and helper functions for the great-circle distance pipeline.
package gcd_pkg;

  localparam int CORDIC_STEPS = 32;

  localparam int ANG_W  = 38;
  localparam int XY_W   = 36;
  localparam int TRIG_W = 32;
  localparam int TERM_W = 34;
  localparam int DIST_W = 25;
  localparam int RAD_W  = 23;
  localparam int PROD_W = 58;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  localparam logic signed [ANG_W-1:0] PI_Q32 =
    ANG_W'((PI_Q60 + (64'd1 << 27)) >> 28);
  localparam logic signed [ANG_W-1:0] TWO_PI_Q32 = PI_Q32 <<< 1;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q32 =
    ANG_W'((PI_Q60 + (64'd1 << 28)) >> 29);
  localparam logic signed [ANG_W-1:0] QUARTER_PI_Q32 =
    ANG_W'((PI_Q60 + (64'd1 << 29)) >> 30);

  localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;

  localparam logic [RAD_W-1:0]  EARTH_RADIUS_M = 23'd6372795;
  localparam logic [DIST_W-1:0] MAX_DIST_M     = 25'd20020726;

  // Restoring long division, used only while building constant tables
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Arctangent of 2^-i in Q.32 from the odd power series in Q.60
  function automatic logic signed [ANG_W-1:0] atan_pow2(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int          sh;
    acc = '0;
    if (i == 0) begin
      return QUARTER_PI_Q32;
    end
    for (int k = 0; k < 31; k++) begin
      sh = i * (2 * k + 1);
      if (sh <= 60) begin
        term = div_u64(64'd1 << (60 - sh), 64'(2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return ANG_W'((acc + (64'd1 << 27)) >> 28);
  endfunction

  // Q.30 product rounded half up
  function automatic logic signed [TRIG_W-1:0] mul_q30(
    input logic signed [TRIG_W-1:0] a,
    input logic signed [TRIG_W-1:0] b
  );
    logic signed [63:0] p;
    p = a * b;
    p = p + (64'sd1 <<< 29);
    return p[61:30];
  endfunction

endpackage

@@ rtl/gcd_rot.sv @@
// Rotation-mode CORDIC pipeline: angle reduction, then one stage per iteration, giving sine and cosine.
module gcd_rot (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [gcd_pkg::ANG_W-1:0]    in_th,
  output logic                                out_valid,
  output logic signed [gcd_pkg::TRIG_W-1:0]   out_sin,
  output logic signed [gcd_pkg::TRIG_W-1:0]   out_cos
);

  localparam int N = gcd_pkg::CORDIC_STEPS;

  logic signed [gcd_pkg::ANG_W-1:0] th1_nxt, th1_r;
  logic signed [gcd_pkg::ANG_W-1:0] th2_nxt, th2_r;
  logic signed [gcd_pkg::ANG_W-1:0] th3_nxt;
  logic                             neg3_nxt;
  logic                             v1_r, v2_r;

  logic signed [gcd_pkg::XY_W-1:0]  x_r [0:N];
  logic signed [gcd_pkg::XY_W-1:0]  y_r [0:N];
  logic signed [gcd_pkg::ANG_W-1:0] z_r [0:N];
  logic                             neg_r [0:N];
  logic                             v_r [0:N];

  logic signed [gcd_pkg::XY_W-1:0]  sin_nxt, cos_nxt;
  logic                             vo_r;
  logic signed [gcd_pkg::TRIG_W-1:0] sin_r, cos_r;

  // Bring angles above pi down by full turns
  always_comb begin
    th1_nxt = in_th;
    if (th1_nxt > gcd_pkg::PI_Q32) begin
      th1_nxt = th1_nxt - gcd_pkg::TWO_PI_Q32;
    end
    if (th1_nxt > gcd_pkg::PI_Q32) begin
      th1_nxt = th1_nxt - gcd_pkg::TWO_PI_Q32;
    end
  end

  // Bring angles below minus pi up by full turns
  always_comb begin
    th2_nxt = th1_r;
    if (th2_nxt < -gcd_pkg::PI_Q32) begin
      th2_nxt = th2_nxt + gcd_pkg::TWO_PI_Q32;
    end
    if (th2_nxt < -gcd_pkg::PI_Q32) begin
      th2_nxt = th2_nxt + gcd_pkg::TWO_PI_Q32;
    end
  end

  // Fold into the right half plane by a half turn
  always_comb begin
    th3_nxt  = th2_r;
    neg3_nxt = 1'b0;
    if (th2_r > gcd_pkg::HALF_PI_Q32) begin
      th3_nxt  = th2_r - gcd_pkg::PI_Q32;
      neg3_nxt = 1'b1;
    end else if (th2_r < -gcd_pkg::HALF_PI_Q32) begin
      th3_nxt  = th2_r + gcd_pkg::PI_Q32;
      neg3_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v_r[0] <= 1'b0;
    end else if (en) begin
      v1_r   <= in_valid;
      v2_r   <= v1_r;
      v_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th1_r    <= th1_nxt;
      th2_r    <= th2_nxt;
      x_r[0]   <= gcd_pkg::XY_W'(gcd_pkg::INV_GAIN_Q30);
      y_r[0]   <= '0;
      z_r[0]   <= th3_nxt;
      neg_r[0] <= neg3_nxt;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [gcd_pkg::ANG_W-1:0] A = gcd_pkg::atan_pow2(i);
    logic signed [gcd_pkg::XY_W-1:0]  x_nxt, y_nxt;
    logic signed [gcd_pkg::ANG_W-1:0] z_nxt;

    always_comb begin
      if (z_r[i] >= 0) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - A;
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + A;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]   <= x_nxt;
        y_r[i+1]   <= y_nxt;
        z_r[i+1]   <= z_nxt;
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // Undo the half turn on the way out
  always_comb begin
    sin_nxt = neg_r[N] ? -y_r[N] : y_r[N];
    cos_nxt = neg_r[N] ? -x_r[N] : x_r[N];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt[gcd_pkg::TRIG_W-1:0];
      cos_r <= cos_nxt[gcd_pkg::TRIG_W-1:0];
    end
  end

  assign out_valid = vo_r;
  assign out_sin   = sin_r;
  assign out_cos   = cos_r;

endmodule

@@ rtl/gcd_terms.sv @@
// Product stages forming the two cross terms and the dot term from the sines and cosines.
module gcd_terms (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [gcd_pkg::TRIG_W-1:0]  in_s1,
  input  logic signed [gcd_pkg::TRIG_W-1:0]  in_c1,
  input  logic signed [gcd_pkg::TRIG_W-1:0]  in_s2,
  input  logic signed [gcd_pkg::TRIG_W-1:0]  in_c2,
  input  logic signed [gcd_pkg::TRIG_W-1:0]  in_sd,
  input  logic signed [gcd_pkg::TRIG_W-1:0]  in_cd,
  output logic                               out_valid,
  output logic signed [gcd_pkg::TERM_W-1:0]  out_cross1,
  output logic signed [gcd_pkg::TERM_W-1:0]  out_cross2,
  output logic signed [gcd_pkg::TERM_W-1:0]  out_dot
);

  logic                              v1_r, v2_r, v3_r;
  logic signed [gcd_pkg::TRIG_W-1:0] c2sd_r, c1s2_r, s1c2_r, s1s2_r, c1c2_r, cd_r;
  logic signed [gcd_pkg::TRIG_W-1:0] c2sd2_r, c1s2_2_r, s1s2_2_r, m1_r, m2_r;
  logic signed [gcd_pkg::TERM_W-1:0] cross1_r, cross2_r, dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // First products
  always_ff @(posedge clk) begin
    if (en) begin
      c2sd_r <= gcd_pkg::mul_q30(in_c2, in_sd);
      c1s2_r <= gcd_pkg::mul_q30(in_c1, in_s2);
      s1c2_r <= gcd_pkg::mul_q30(in_s1, in_c2);
      s1s2_r <= gcd_pkg::mul_q30(in_s1, in_s2);
      c1c2_r <= gcd_pkg::mul_q30(in_c1, in_c2);
      cd_r   <= in_cd;
    end
  end

  // Products with the longitude cosine
  always_ff @(posedge clk) begin
    if (en) begin
      m1_r     <= gcd_pkg::mul_q30(s1c2_r, cd_r);
      m2_r     <= gcd_pkg::mul_q30(c1c2_r, cd_r);
      c2sd2_r  <= c2sd_r;
      c1s2_2_r <= c1s2_r;
      s1s2_2_r <= s1s2_r;
    end
  end

  // Combine into the three terms
  always_ff @(posedge clk) begin
    if (en) begin
      cross1_r <= gcd_pkg::TERM_W'(c2sd2_r);
      cross2_r <= gcd_pkg::TERM_W'(c1s2_2_r) - gcd_pkg::TERM_W'(m1_r);
      dot_r    <= gcd_pkg::TERM_W'(s1s2_2_r) + gcd_pkg::TERM_W'(m2_r);
    end
  end

  assign out_valid  = v3_r;
  assign out_cross1 = cross1_r;
  assign out_cross2 = cross2_r;
  assign out_dot    = dot_r;

endmodule

@@ rtl/gcd_vec.sv @@
// Vectoring-mode CORDIC pipeline: quarter-turn pre-rotation, then one stage per iteration.
module gcd_vec (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [gcd_pkg::XY_W-1:0]    in_x,
  input  logic signed [gcd_pkg::XY_W-1:0]    in_y,
  output logic                               out_valid,
  output logic signed [gcd_pkg::XY_W-1:0]    out_mag,
  output logic signed [gcd_pkg::ANG_W-1:0]   out_ang
);

  localparam int N = gcd_pkg::CORDIC_STEPS;

  logic signed [gcd_pkg::XY_W-1:0]  x_r [0:N];
  logic signed [gcd_pkg::XY_W-1:0]  y_r [0:N];
  logic signed [gcd_pkg::ANG_W-1:0] z_r [0:N];
  logic                             v_r [0:N];

  logic signed [gcd_pkg::XY_W-1:0]  x0_nxt, y0_nxt;
  logic signed [gcd_pkg::ANG_W-1:0] z0_nxt;

  // Pre-rotate a vector in the left half plane by a quarter turn
  always_comb begin
    x0_nxt = in_x;
    y0_nxt = in_y;
    z0_nxt = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x0_nxt = in_y;
        y0_nxt = -in_x;
        z0_nxt = gcd_pkg::HALF_PI_Q32;
      end else begin
        x0_nxt = -in_y;
        y0_nxt = in_x;
        z0_nxt = -gcd_pkg::HALF_PI_Q32;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x0_nxt;
      y_r[0] <= y0_nxt;
      z_r[0] <= z0_nxt;
    end
  end

  // Drive y toward zero, one step per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [gcd_pkg::ANG_W-1:0] A = gcd_pkg::atan_pow2(i);
    logic signed [gcd_pkg::XY_W-1:0]  x_nxt, y_nxt;
    logic signed [gcd_pkg::ANG_W-1:0] z_nxt;

    always_comb begin
      if (y_r[i] >= 0) begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + A;
      end else begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - A;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
      end
    end
  end

  assign out_valid = v_r[N];
  assign out_mag   = x_r[N];
  assign out_ang   = z_r[N];

endmodule

@@ rtl/great_circle_distance.sv @@
// Top level of the great-circle distance pipeline: trig lanes, terms, two vectorings, scaling.
//
// Usage:
//   Input channel in_*: one position pair per request (in_lat_a, in_lon_a, in_lat_b,
//   in_lon_b, radians; latitudes in signed Q2.29, longitudes in signed Q3.29). A request
//   is taken on a rising edge with in_valid high and in_stall low.
//   Output channel out_*: one distance per request, out_distance_m in whole meters,
//   rounded and saturated at half the circumference; taken with out_valid high and
//   out_stall low. Results leave in request order.
// Throughput: one request per cycle, sustained, while the receiver takes results.
// Path: the three chained CORDIC pipelines (sine/cosine, hypot, atan2) lie between
//   request and result.
// Stall: the output register plus a one-entry skid buffer part the sides. When the
//   receiver stalls and the skid buffer fills, in_stall rises and the whole pipeline
//   holds its contents; nothing is dropped or repeated.
// Reset: synchronous, active low rst_n clears all valid bits; the pipeline is empty
//   and ready to take a request in the first cycle after reset.
module great_circle_distance (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [30:0]                 in_lat_a,
  input  logic signed [31:0]                 in_lon_a,
  input  logic signed [30:0]                 in_lat_b,
  input  logic signed [31:0]                 in_lon_b,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gcd_pkg::DIST_W-1:0]         out_distance_m
);

  localparam int VEC_LAT = 1 + gcd_pkg::CORDIC_STEPS;

  logic                                en;
  logic signed [gcd_pkg::ANG_W-1:0]    lat1_th, lat2_th, dlon_th;
  logic signed [32:0]                  dlon_raw;

  logic                                rot_valid;
  logic signed [gcd_pkg::TRIG_W-1:0]   s1, c1, s2, c2, sd, cd;

  logic                                t_valid;
  logic signed [gcd_pkg::TERM_W-1:0]   cross1, cross2, dot;

  logic                                v1_valid;
  logic signed [gcd_pkg::XY_W-1:0]     v1_mag;
  logic signed [gcd_pkg::ANG_W-1:0]    v1_ang;

  logic signed [gcd_pkg::TERM_W-1:0]   dot_d_r [0:VEC_LAT-1];

  logic signed [63:0]                  magp_nxt;
  logic                                m_valid_r;
  logic signed [gcd_pkg::TRIG_W-1:0]   magn_r;
  logic signed [gcd_pkg::TERM_W-1:0]   dotm_r;

  logic                                v2_valid;
  logic signed [gcd_pkg::XY_W-1:0]     v2_mag;
  logic signed [gcd_pkg::ANG_W-1:0]    v2_ang;

  logic [34:0]                         angc_nxt;
  logic                                s1_valid_r, s2_valid_r;
  logic [gcd_pkg::PROD_W-1:0]          prod_r;
  logic [gcd_pkg::PROD_W-1:0]          prodr_nxt;
  logic [gcd_pkg::DIST_W-1:0]          dist_nxt, dist_r;

  logic                                out_valid_r, out_valid_nxt;
  logic [gcd_pkg::DIST_W-1:0]          out_dist_r, out_dist_nxt;
  logic                                sk_valid_r, sk_valid_nxt;
  logic [gcd_pkg::DIST_W-1:0]          sk_dist_r, sk_dist_nxt;

  // Advance the pipeline whenever the skid buffer is free
  assign en       = !sk_valid_r;
  assign in_stall = sk_valid_r;

  // Scale inputs to Q.32 angles
  always_comb begin
    lat1_th  = gcd_pkg::ANG_W'(in_lat_a) <<< 3;
    lat2_th  = gcd_pkg::ANG_W'(in_lat_b) <<< 3;
    dlon_raw = 33'(in_lon_b) - 33'(in_lon_a);
    dlon_th  = gcd_pkg::ANG_W'(dlon_raw) <<< 3;
  end

  gcd_rot u_rot_lat1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_th     (lat1_th),
    .out_valid (rot_valid),
    .out_sin   (s1),
    .out_cos   (c1)
  );

  gcd_rot u_rot_lat2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_th     (lat2_th),
    .out_valid (),
    .out_sin   (s2),
    .out_cos   (c2)
  );

  gcd_rot u_rot_dlon (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_th     (dlon_th),
    .out_valid (),
    .out_sin   (sd),
    .out_cos   (cd)
  );

  gcd_terms u_terms (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (rot_valid),
    .in_s1      (s1),
    .in_c1      (c1),
    .in_s2      (s2),
    .in_c2      (c2),
    .in_sd      (sd),
    .in_cd      (cd),
    .out_valid  (t_valid),
    .out_cross1 (cross1),
    .out_cross2 (cross2),
    .out_dot    (dot)
  );

  // Hypot of the cross terms
  gcd_vec u_vec_hyp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (t_valid),
    .in_x      (gcd_pkg::XY_W'(cross1)),
    .in_y      (gcd_pkg::XY_W'(cross2)),
    .out_valid (v1_valid),
    .out_mag   (v1_mag),
    .out_ang   (v1_ang)
  );

  // Delay the dot term alongside the hypot pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      dot_d_r[0] <= dot;
    end
  end

  for (genvar k = 1; k < VEC_LAT; k++) begin : g_dot_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dot_d_r[k] <= dot_d_r[k-1];
      end
    end
  end

  // Remove the CORDIC gain from the magnitude
  always_comb begin
    magp_nxt = $signed(v1_mag[32:0]) * gcd_pkg::INV_GAIN_Q30;
    magp_nxt = magp_nxt + (64'sd1 <<< 29);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= v1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      magn_r <= magp_nxt[61:30];
      dotm_r <= dot_d_r[VEC_LAT-1];
    end
  end

  // Central angle as atan2 of hypot over dot
  gcd_vec u_vec_ang (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (m_valid_r),
    .in_x      (gcd_pkg::XY_W'(dotm_r)),
    .in_y      (gcd_pkg::XY_W'(magn_r)),
    .out_valid (v2_valid),
    .out_mag   (v2_mag),
    .out_ang   (v2_ang)
  );

  // Clamp negative angles and scale by the earth radius
  always_comb begin
    angc_nxt = (v2_ang < 0) ? '0 : v2_ang[34:0];
  end

  // Round to whole meters and saturate
  always_comb begin
    prodr_nxt = prod_r + (gcd_pkg::PROD_W'(1) << 31);
    if (prodr_nxt[gcd_pkg::PROD_W-1:32] >
        (gcd_pkg::PROD_W - 32)'(gcd_pkg::MAX_DIST_M)) begin
      dist_nxt = gcd_pkg::MAX_DIST_M;
    end else begin
      dist_nxt = prodr_nxt[32 +: gcd_pkg::DIST_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= v2_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= gcd_pkg::PROD_W'(angc_nxt) * gcd_pkg::PROD_W'(gcd_pkg::EARTH_RADIUS_M);
      dist_r <= dist_nxt;
    end
  end

  // Output register with a one-entry skid buffer
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_dist_nxt  = out_dist_r;
    sk_valid_nxt  = sk_valid_r;
    sk_dist_nxt   = sk_dist_r;
    if (!sk_valid_r) begin
      if (out_valid_r && out_stall) begin
        if (s2_valid_r) begin
          sk_valid_nxt = 1'b1;
          sk_dist_nxt  = dist_r;
        end
      end else begin
        out_valid_nxt = s2_valid_r;
        out_dist_nxt  = dist_r;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b1;
      out_dist_nxt  = sk_dist_r;
      sk_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sk_valid_r  <= sk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dist_r <= out_dist_nxt;
    sk_dist_r  <= sk_dist_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_distance_m = out_dist_r;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the great-circle distance pipeline.
`timescale 1ns / 1ps

module tb;

  localparam int LAT_MAX   = 843314857;
  localparam int LON_MAX   = 1686629713;
  localparam int N_RANDOM  = 1000;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_WAIT = 3 * gcd_pkg::CORDIC_STEPS + 30;

  // Fixed-point distance predictor and in-order store of expected distances
  class distance_scoreboard;
    longint       atan_q32[gcd_pkg::CORDIC_STEPS];
    longint       pi_q32, half_pi_q32;
    logic [24:0]  pending_dist[$];
    int           errors;
    int           checked;

    function new();
      longint unsigned pi_q60, acc, term;
      int              sh;
      pi_q60 = 64'h3243F6A8885A308D;
      pi_q32 = longint'((pi_q60 + (64'd1 << 27)) >> 28);
      half_pi_q32 = longint'((pi_q60 + (64'd1 << 28)) >> 29);
      atan_q32[0] = longint'((pi_q60 + (64'd1 << 29)) >> 30);
      for (int i = 1; i < gcd_pkg::CORDIC_STEPS; i++) begin
        acc = 0;
        for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
          sh = i * (2 * k + 1);
          term = (64'd1 << (60 - sh)) / longint'(2 * k + 1);
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
        atan_q32[i] = longint'((acc + (64'd1 << 27)) >> 28);
      end
      errors = 0;
      checked = 0;
    endfunction

    function longint mulq(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Rotate a unit vector by th; fold into the right half plane first
    function void rotate(input longint th, output longint s, output longint c);
      longint x, y, z, dx, dy;
      bit     flip;
      x = 652032874;
      y = 0;
      flip = 0;
      if (th > pi_q32) th -= 2 * pi_q32;
      if (th > pi_q32) th -= 2 * pi_q32;
      if (th < -pi_q32) th += 2 * pi_q32;
      if (th < -pi_q32) th += 2 * pi_q32;
      if (th > half_pi_q32) begin
        th -= pi_q32;
        flip = 1;
      end else if (th < -half_pi_q32) begin
        th += pi_q32;
        flip = 1;
      end
      z = th;
      for (int i = 0; i < gcd_pkg::CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_q32[i];
        end else begin
          x += dx; y -= dy; z += atan_q32[i];
        end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    // Drive y to zero; returns scaled magnitude and angle
    function void vectoring(input longint x, input longint y, output longint mag,
                            output longint ang);
      longint z, t, dx, dy;
      z = 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = half_pi_q32;
        end else begin
          x = -y; y = t; z = -half_pi_q32;
        end
      end
      for (int i = 0; i < gcd_pkg::CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_q32[i];
        end else begin
          x -= dx; y += dy; z -= atan_q32[i];
        end
      end
      mag = x;
      ang = z;
    endfunction

    // Note an accepted request and queue its distance
    function void note_request(logic signed [30:0] la, logic signed [31:0] oa,
                               logic signed [30:0] lb, logic signed [31:0] ob);
      longint s1, c1, s2, c2, sd, cd, cr1, cr2, dotp, mag, ang, unused, meters;
      rotate(longint'(la) * 8, s1, c1);
      rotate(longint'(lb) * 8, s2, c2);
      rotate((longint'(ob) - longint'(oa)) * 8, sd, cd);
      cr1 = mulq(c2, sd);
      cr2 = mulq(c1, s2) - mulq(mulq(s1, c2), cd);
      dotp = mulq(s1, s2) + mulq(mulq(c1, c2), cd);
      vectoring(cr1, cr2, mag, unused);
      mag = mulq(mag, 652032874);
      vectoring(dotp, mag, unused, ang);
      if (ang < 0) ang = 0;
      meters = (ang * 6372795 + (64'sd1 <<< 31)) >>> 32;
      if (meters > 20020726) meters = 20020726;
      pending_dist.push_back(meters[24:0]);
    endfunction

    function void report(string what);
      $display("%0t MISMATCH: %s", $realtime, what);
      errors++;
    endfunction

    // Compare a returned distance with the oldest expectation
    function void check_result(logic [24:0] got);
      logic [24:0] want;
      checked++;
      if (pending_dist.size() == 0) begin
        report($sformatf("distance %0d with no request waiting", got));
        return;
      end
      want = pending_dist.pop_front();
      if (got !== want)
        report($sformatf("distance_m got %0d want %0d", got, want));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [30:0] in_lat_a;
  logic signed [31:0] in_lon_a;
  logic signed [30:0] in_lat_b;
  logic signed [31:0] in_lon_b;
  logic               out_valid;
  logic               out_stall;
  logic [gcd_pkg::DIST_W-1:0] out_distance_m;

  distance_scoreboard sb = new();
  logic hold_req;
  int   idle_cycles;
  int   directed_cnt;

  great_circle_distance dut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Receiver: check results, stall on a shifting pattern, honor long holds
  int rx_mode, rx_left, hold_left;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_distance_m);
    if (hold_req && hold_left == 0) hold_left = LONG_HOLD;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(10, 80);
    end
    rx_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  int burst_left;

  // Offer one request and hold it until taken; often idle between bursts
  task automatic send_request(int la, int oa, int lb, int ob);
    int gap;
    in_valid <= 1'b1;
    in_lat_a <= la[30:0];
    in_lon_a <= oa;
    in_lat_b <= lb[30:0];
    in_lon_b <= ob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(la[30:0], oa, lb[30:0], ob);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Wait until every queued distance has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_dist.size() != 0) @(posedge clk);
  endtask

  function automatic int rand_lat();
    return int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
  endfunction

  function automatic int rand_lon();
    return int'($urandom_range(0, 2 * LAT_MAX)) * 2 - LON_MAX;
  endfunction

  function automatic int near(int v, int spread);
    return v + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  int la, oa, lb, ob, kind;

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_lat_a <= '0;
    in_lon_a <= '0;
    in_lat_b <= '0;
    in_lon_b <= '0;
    out_stall <= 1'b0;
    hold_req <= 1'b0;
    idle_cycles = 0;
    rx_left = 0;
    hold_left = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, field extremes, poles, antipodes, wrapped longitude
    send_request(0, 0, 0, 0);
    send_request(LAT_MAX, 0, -LAT_MAX, 0);
    send_request(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_request(0, 0, 0, LON_MAX);
    send_request(0, -LON_MAX, 0, LON_MAX);
    send_request(0, -LON_MAX, 0, 0);
    send_request(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
    send_request(123456789, -987654321, 123456789, -987654321);
    send_request(123456789, -987654321, 123456790, -987654320);
    send_request(400000000, 0, -400000000, LON_MAX);
    send_request(-400000000, 1000, 400000001, 1000 - LON_MAX);
    send_request(-(1 << 30), 32'h8000_0000, (1 << 30) - 1, 32'h7FFF_FFFF);
    send_request((1 << 30) - 1, 32'h7FFF_FFFF, -(1 << 30), 32'h8000_0000);
    send_request(-(1 << 30), 0, -(1 << 30), 32'h8000_0000);
    send_request(0, 32'h8000_0000, 0, 32'h7FFF_FFFF);
    send_request(LAT_MAX, 0, LAT_MAX, LON_MAX);
    send_request(1, 0, 0, 1);
    send_request(-1, -1, 1, 1);
    send_request(300000000, 500000000, -300000000, -1186629713);
    send_request(0, 843314857, 0, -843314856);
    directed_cnt = 20;
    drain();

    // Random: mostly in-range, some near pairs and antipodes, some raw bits
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        la = rand_lat(); oa = rand_lon(); lb = rand_lat(); ob = rand_lon();
      end else if (kind < 14) begin
        la = rand_lat(); oa = rand_lon();
        lb = near(la, 2000); ob = near(oa, 2000);
      end else if (kind < 16) begin
        la = rand_lat(); oa = rand_lon();
        lb = near(-la, 2000);
        ob = (oa > 0) ? near(oa - LON_MAX, 2000) : near(oa + LON_MAX, 2000);
      end else begin
        la = $urandom(); oa = $urandom(); lb = $urandom(); ob = $urandom();
      end
      // Hold off the receiver while requests keep coming
      if (n == 300) hold_req <= 1'b1;
      if (n == 301) hold_req <= 1'b0;
      send_request(la, oa, lb, ob);
      // Pause the sender until everything is back
      if (n == 650) drain();
    end
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d directed and %0d random position pairs, %0d distances checked.",
             directed_cnt, N_RANDOM, sb.checked);
    $display("Included a %0d-cycle receiver hold and a full drain mid-run.", LONG_HOLD);
    if (sb.errors == 0 && sb.pending_dist.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ great_circle_distance.f @@
rtl/gcd_pkg.sv
rtl/gcd_rot.sv
rtl/gcd_terms.sv
rtl/gcd_vec.sv
rtl/great_circle_distance.sv
dv/tb.sv
